>>> sv/lgs_pkg.sv
`timescale 1ns / 1ps
package lgs_pkg;

  localparam int MaxTopics  = 64;
  localparam int MaxVocab   = 4096;
  localparam int MaxDocs    = 1024;
  localparam int CountBits  = 24;
  localparam int TopicBits  = 6;
  localparam int WordBits   = 12;
  localparam int DocBits    = 10;
  localparam int KBits      = 7;
  localparam int VBits      = 13;
  localparam int PriorBits  = 24;
  localparam int TotBits    = 32;
  localparam int SumBits    = 40;
  localparam int DivBits    = 50;
  localparam int ClrBits    = TopicBits + WordBits;

  localparam logic [1:0] CFG_ALPHA  = 2'd0;
  localparam logic [1:0] CFG_BETA   = 2'd1;
  localparam logic [1:0] CFG_TOPICS = 2'd2;
  localparam logic [1:0] CFG_VOCAB  = 2'd3;

  localparam logic OP_ADD      = 1'b0;
  localparam logic OP_RESAMPLE = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [DocBits-1:0]   doc_index;
    logic [WordBits-1:0]  word_id;
    logic [TopicBits-1:0] topic_in;
    logic [31:0]          random_fraction;
  } in_t;

  typedef struct packed {
    logic [TopicBits-1:0] topic_out;
    logic                 count_error;
  } out_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RRD, S_RCHK, S_KRD, S_KDAT, S_DIV1, S_DIV2, S_ACC,
    S_THR1, S_THR2, S_SRD, S_SCMP, S_ARD, S_AWR, S_DONE
  } state_t;

endpackage

>>> sv/lgs_ram.sv
`timescale 1ns / 1ps
module lgs_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> sv/lgs_div.sv
`timescale 1ns / 1ps
module lgs_div import lgs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DivBits-1:0] num,
  input  logic [DivBits-1:0] den,
  output logic               done,
  output logic [31:0]        quo
);
  logic               busy_r, busy_nxt, done_r, done_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic [DivBits-1:0] rem_r, rem_nxt, den_r, den_nxt;
  logic [31:0]        q_r, q_nxt;
  logic [DivBits-1:0] rem_sh;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    rem_sh   = {rem_r[DivBits-2:0], 1'b0};
    if (start && !busy_r) begin
      if (den == '0) begin
        q_nxt    = '0;
        done_nxt = 1'b1;
      end else if (num >= den) begin
        q_nxt    = '1;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = num;
        den_nxt  = den;
        cnt_nxt  = '0;
        q_nxt    = '0;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      // restoring step, one quotient bit a cycle
      if (rem_sh >= den_r) begin
        rem_nxt = rem_sh - den_r;
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule

>>> sv/lda_collapsed_gibbs_token_sampler_core.sv
`timescale 1ns / 1ps
// add token: read in S_ARD, write in S_AWR, result in S_DONE when the output is free
// resample: per topic a read, two passes through the shared restoring divider and an
// accumulate, then a read and a compare per topic to scan the cumulative weights; a
// count error goes straight to S_DONE; one transaction at a time
// reset: a clearing pass over every word-topic address zeroes all count memories,
// in_ready stays low meanwhile; configuration writes are taken at any time
module lda_collapsed_gibbs_token_sampler_core import lgs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [PriorBits-1:0] cfg_data
);
  state_t state_r, state_nxt;
  logic [PriorBits-1:0] alpha_r, beta_r;
  logic [KBits-1:0]     topics_r;
  logic [VBits-1:0]     vocab_r;
  logic [ClrBits-1:0]   clr_r, clr_nxt;
  in_t                  item_r, item_nxt;
  logic [KBits-1:0]     kuse_r, kuse_nxt, k_r, k_nxt;
  logic [TopicBits-1:0] t_r, t_nxt;
  logic                 err_r, err_nxt;
  logic [36:0]          vbeta_r, vbeta_nxt;
  logic [30:0]          kalpha_r, kalpha_nxt;
  logic [40:0]          den2_r, den2_nxt, n2_r, n2_nxt;
  logic [31:0]          r1_r, r1_nxt;
  logic [63:0]          prod_r, prod_nxt, plo_r, plo_nxt;
  logic [SumBits-1:0]   sum_r, sum_nxt, thr_r, thr_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_t                 out_r, out_nxt;

  logic [KBits-1:0]     kuse_c;
  logic [VBits-1:0]     vuse_c;
  logic [TopicBits-1:0] t_c, rd_topic;
  logic [SumBits:0]     sum_add;

  logic                 cnt_we, cw_we;
  logic [CountBits-1:0] wt_q, dt_q, dl_q, wt_w, dt_w, dl_w;
  logic [TotBits-1:0]   tt_q, tt_w;
  logic [SumBits-1:0]   cw_q;
  logic [17:0]          wt_wa, wt_ra;
  logic [15:0]          dt_wa, dt_ra;
  logic [TopicBits-1:0] tt_wa;
  logic [DocBits-1:0]   dl_wa;

  logic               div_start, div_done;
  logic [DivBits-1:0] div_num, div_den;
  logic [31:0]        div_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r  <= 24'd51200;
      beta_r   <= 24'd6554;
      topics_r <= 7'd64;
      vocab_r  <= 13'd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALPHA:  alpha_r  <= cfg_data;
        CFG_BETA:   beta_r   <= cfg_data;
        CFG_TOPICS: topics_r <= cfg_data[KBits-1:0];
        CFG_VOCAB:  vocab_r  <= cfg_data[VBits-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    if (topics_r == '0) kuse_c = 7'd1;
    else if (topics_r > 7'd64) kuse_c = 7'd64;
    else kuse_c = topics_r;
    if (vocab_r == '0) vuse_c = 13'd1;
    else if (vocab_r > 13'd4096) vuse_c = 13'd4096;
    else vuse_c = vocab_r;
    if ({1'b0, in_data.topic_in} >= kuse_c) t_c = TopicBits'(kuse_c - 7'd1);
    else t_c = in_data.topic_in;
  end

  assign rd_topic = (state_r == S_KRD) ? k_r[TopicBits-1:0] : t_r;
  assign wt_ra = {rd_topic, item_r.word_id};
  assign dt_ra = {item_r.doc_index, rd_topic};
  assign sum_add = {1'b0, sum_r} + {9'd0, prod_r[63:32]};

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    item_nxt      = item_r;
    kuse_nxt      = kuse_r;
    k_nxt         = k_r;
    t_nxt         = t_r;
    err_nxt       = err_r;
    vbeta_nxt     = vbeta_r;
    kalpha_nxt    = kalpha_r;
    den2_nxt      = den2_r;
    n2_nxt        = n2_r;
    r1_nxt        = r1_r;
    prod_nxt      = prod_r;
    plo_nxt       = plo_r;
    sum_nxt       = sum_r;
    thr_nxt       = thr_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cnt_we        = 1'b0;
    cw_we         = 1'b0;
    wt_wa = {t_r, item_r.word_id};
    dt_wa = {item_r.doc_index, t_r};
    tt_wa = t_r;
    dl_wa = item_r.doc_index;
    wt_w  = (wt_q == '1) ? wt_q : wt_q + 1'b1;
    dt_w  = (dt_q == '1) ? dt_q : dt_q + 1'b1;
    tt_w  = (tt_q == '1) ? tt_q : tt_q + 1'b1;
    dl_w  = (dl_q == '1) ? dl_q : dl_q + 1'b1;
    div_start = 1'b0;
    div_num   = {10'd0, wt_q, 16'd0} + {26'd0, beta_r};
    div_den   = {2'd0, tt_q, 16'd0} + {13'd0, vbeta_r};
    case (state_r)
      S_CLEAR: begin
        cnt_we = 1'b1;
        wt_wa = clr_r;
        dt_wa = clr_r[15:0];
        tt_wa = clr_r[TopicBits-1:0];
        dl_wa = clr_r[DocBits-1:0];
        wt_w = '0; dt_w = '0; tt_w = '0; dl_w = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt   = in_data;
          kuse_nxt   = kuse_c;
          t_nxt      = t_c;
          err_nxt    = 1'b0;
          vbeta_nxt  = vuse_c * beta_r;
          kalpha_nxt = kuse_c * alpha_r;
          state_nxt  = (in_data.op == OP_RESAMPLE) ? S_RRD : S_ARD;
        end
      end
      S_RRD: state_nxt = S_RCHK;
      S_RCHK: begin
        if (wt_q == '0 || dt_q == '0 || tt_q == '0 || dl_q == '0) begin
          err_nxt   = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cnt_we = 1'b1;
          wt_w = wt_q - 1'b1;
          dt_w = dt_q - 1'b1;
          tt_w = tt_q - 1'b1;
          dl_w = dl_q - 1'b1;
          den2_nxt  = {1'b0, dl_w, 16'd0} + {10'd0, kalpha_r};
          sum_nxt   = '0;
          k_nxt     = '0;
          state_nxt = S_KRD;
        end
      end
      S_KRD: state_nxt = S_KDAT;
      S_KDAT: begin
        div_start = 1'b1;
        n2_nxt    = {1'b0, dt_q, 16'd0} + {17'd0, alpha_r};
        state_nxt = S_DIV1;
      end
      S_DIV1: begin
        if (div_done) begin
          r1_nxt    = div_q;
          div_start = 1'b1;
          div_num   = {9'd0, n2_r};
          div_den   = {9'd0, den2_r};
          state_nxt = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_done) begin
          prod_nxt  = r1_r * div_q;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        sum_nxt = sum_add[SumBits] ? '1 : sum_add[SumBits-1:0];
        cw_we   = 1'b1;
        k_nxt   = k_r + 1'b1;
        if (k_r + 1'b1 == kuse_r) state_nxt = S_THR1;
        else state_nxt = S_KRD;
      end
      S_THR1: begin
        plo_nxt   = item_r.random_fraction * sum_r[31:0];
        state_nxt = S_THR2;
      end
      S_THR2: begin
        thr_nxt   = item_r.random_fraction * sum_r[39:32] + {8'd0, plo_r[63:32]};
        k_nxt     = '0;
        state_nxt = S_SRD;
      end
      S_SRD: state_nxt = S_SCMP;
      S_SCMP: begin
        if (cw_q > thr_r) begin
          t_nxt     = k_r[TopicBits-1:0];
          state_nxt = S_ARD;
        end else if (k_r + 1'b1 == kuse_r) begin
          t_nxt     = TopicBits'(kuse_r - 7'd1);
          state_nxt = S_ARD;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_ARD: state_nxt = S_AWR;
      S_AWR: begin
        cnt_we    = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.topic_out   = t_r;
          out_nxt.count_error = err_r;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r   <= item_nxt;
    kuse_r   <= kuse_nxt;
    k_r      <= k_nxt;
    t_r      <= t_nxt;
    err_r    <= err_nxt;
    vbeta_r  <= vbeta_nxt;
    kalpha_r <= kalpha_nxt;
    den2_r   <= den2_nxt;
    n2_r     <= n2_nxt;
    r1_r     <= r1_nxt;
    prod_r   <= prod_nxt;
    plo_r    <= plo_nxt;
    sum_r    <= sum_nxt;
    thr_r    <= thr_nxt;
    out_r    <= out_nxt;
  end

  lgs_ram #(.DEPTH(MaxTopics * MaxVocab), .WIDTH(CountBits)) u_wt (
    .clk(clk), .we(cnt_we), .waddr(wt_wa), .wdata(wt_w), .raddr(wt_ra), .rdata(wt_q)
  );
  lgs_ram #(.DEPTH(MaxDocs * MaxTopics), .WIDTH(CountBits)) u_dt (
    .clk(clk), .we(cnt_we), .waddr(dt_wa), .wdata(dt_w), .raddr(dt_ra), .rdata(dt_q)
  );
  lgs_ram #(.DEPTH(MaxTopics), .WIDTH(TotBits)) u_tt (
    .clk(clk), .we(cnt_we), .waddr(tt_wa), .wdata(tt_w), .raddr(rd_topic), .rdata(tt_q)
  );
  lgs_ram #(.DEPTH(MaxDocs), .WIDTH(CountBits)) u_dl (
    .clk(clk), .we(cnt_we), .waddr(dl_wa), .wdata(dl_w), .raddr(item_r.doc_index),
    .rdata(dl_q)
  );
  lgs_ram #(.DEPTH(MaxTopics), .WIDTH(SumBits)) u_cw (
    .clk(clk), .we(cw_we), .waddr(k_r[TopicBits-1:0]), .wdata(sum_nxt),
    .raddr(k_r[TopicBits-1:0]), .rdata(cw_q)
  );

  lgs_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r != S_CLEAR)
    else $error("input taken during clearing pass");
  a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV1 || state_r == S_DIV2))
    else $error("divider finished outside a division step");
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside done state");
endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import lgs_pkg::*;

  localparam int unsigned CycleLimit = 20000000;
  localparam int          HoldCycles = 3000;

  class topic_scoreboard;
    bit [23:0] alpha_q = 24'd51200;
    bit [23:0] beta_q  = 24'd6554;
    bit [6:0]  k_reg   = 7'd64;
    bit [12:0] v_reg   = 13'd4096;
    bit [23:0] word_topic[int];
    bit [23:0] doc_topic[int];
    bit [31:0] topic_total[int];
    bit [23:0] doc_len[int];
    out_t      pending_q[$];
    int        errors;

    function void set_reg(logic [1:0] idx, logic [PriorBits-1:0] val);
      case (idx)
        CFG_ALPHA:  alpha_q = val;
        CFG_BETA:   beta_q  = val;
        CFG_TOPICS: k_reg   = val[6:0];
        CFG_VOCAB:  v_reg   = val[12:0];
        default: ;
      endcase
    endfunction

    function bit [31:0] ratio_q32(bit [63:0] num, bit [63:0] den);
      bit [63:0] rem;
      bit [31:0] q;
      if (den == 0) return 32'd0;
      if (num >= den) return 32'hFFFF_FFFF;
      rem = num;
      q = 0;
      for (int i = 0; i < 32; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= den) begin
          rem = rem - den;
          q[0] = 1'b1;
        end
      end
      return q;
    endfunction

    function void add_token(int d, int w, int t);
      int wi;
      int di;
      wi = t * MaxVocab + w;
      di = d * MaxTopics + t;
      if (word_topic[wi] != 24'hFF_FFFF) word_topic[wi]++;
      if (doc_topic[di] != 24'hFF_FFFF) doc_topic[di]++;
      if (topic_total[t] != 32'hFFFF_FFFF) topic_total[t]++;
      if (doc_len[d] != 24'hFF_FFFF) doc_len[d]++;
    endfunction

    // predicts the result of an accepted transaction and updates the tables
    function out_t note_input(in_t x);
      int        k_use;
      int        v_use;
      int        d;
      int        w;
      int        t;
      int        wi;
      int        di;
      bit        err;
      bit [63:0] vbeta;
      bit [63:0] kalpha;
      bit [63:0] den2;
      bit [63:0] n1;
      bit [63:0] d1;
      bit [63:0] n2;
      bit [63:0] wt;
      bit [63:0] sum;
      bit [63:0] thr;
      bit [63:0] frac;
      bit [63:0] cum[MaxTopics];
      out_t      r;
      k_use = k_reg;
      v_use = v_reg;
      if (k_use < 1) k_use = 1;
      if (k_use > MaxTopics) k_use = MaxTopics;
      if (v_use < 1) v_use = 1;
      if (v_use > MaxVocab) v_use = MaxVocab;
      d = x.doc_index;
      w = x.word_id;
      t = x.topic_in;
      if (t >= k_use) t = k_use - 1;
      err = 0;
      if (x.op == OP_ADD) begin
        add_token(d, w, t);
      end else begin
        wi = t * MaxVocab + w;
        di = d * MaxTopics + t;
        if (word_topic[wi] == 0 || doc_topic[di] == 0 || topic_total[t] == 0 ||
            doc_len[d] == 0) begin
          err = 1;
        end else begin
          word_topic[wi]--;
          doc_topic[di]--;
          topic_total[t]--;
          doc_len[d]--;
          vbeta = 64'(v_use) * beta_q;
          kalpha = 64'(k_use) * alpha_q;
          den2 = (64'(doc_len[d]) << 16) + kalpha;
          sum = 0;
          for (int k = 0; k < k_use; k++) begin
            n1 = (64'(word_topic[k * MaxVocab + w]) << 16) + beta_q;
            d1 = (64'(topic_total[k]) << 16) + vbeta;
            n2 = (64'(doc_topic[d * MaxTopics + k]) << 16) + alpha_q;
            wt = (64'(ratio_q32(n1, d1)) * 64'(ratio_q32(n2, den2))) >> 32;
            sum = sum + wt;
            if (sum > 64'hFF_FFFF_FFFF) sum = 64'hFF_FFFF_FFFF;
            cum[k] = sum;
          end
          frac = x.random_fraction;
          thr = frac * (sum >> 32) + ((frac * (sum & 64'hFFFF_FFFF)) >> 32);
          t = k_use - 1;
          for (int k = 0; k < k_use; k++) begin
            if (cum[k] > thr) begin
              t = k;
              break;
            end
          end
          add_token(d, w, t);
        end
      end
      r.topic_out = TopicBits'(t);
      r.count_error = err;
      pending_q.insert(pending_q.size(), r);
      return r;
    endfunction

    task report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check(out_t got);
      out_t want;
      if (pending_q.size() == 0) begin
        report("unexpected result, topic", got.topic_out, -1);
      end else begin
        want = pending_q.pop_front();
        if (got.topic_out !== want.topic_out) report("topic_out", got.topic_out, want.topic_out);
        if (got.count_error !== want.count_error)
          report("count_error", got.count_error, want.count_error);
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [PriorBits-1:0] cfg_data;

  topic_scoreboard sb;
  bit          no_idle;
  bit          hold_req;
  int unsigned cycles;
  int          tok_doc[$];
  int          tok_word[$];
  int          tok_topic[$];

  lda_collapsed_gibbs_token_sampler_core dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .cfg_we, .cfg_index, .cfg_data
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[lda_collapsed_gibbs_token_sampler_core] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check(out_data);
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready = no_idle || ($urandom_range(99) >= 12);
    end
  end

  task send_item(in_t x, output out_t r);
    while (!no_idle && $urandom_range(99) < 12) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = sb.note_input(x);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task wait_drained();
    in_valid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task write_cfg(logic [1:0] idx, logic [PriorBits-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task set_all(int a, int b, int k, int v);
    wait_drained();
    write_cfg(CFG_ALPHA, PriorBits'(a));
    write_cfg(CFG_BETA, PriorBits'(b));
    write_cfg(CFG_TOPICS, PriorBits'(k));
    write_cfg(CFG_VOCAB, PriorBits'(v));
  endtask

  function in_t make_item(bit op, int d, int w, int t);
    in_t x;
    x.op = op;
    x.doc_index = DocBits'(d);
    x.word_id = WordBits'(w);
    x.topic_in = TopicBits'(t);
    x.random_fraction = $urandom;
    return x;
  endfunction

  task random_items(int n);
    in_t  x;
    out_t r;
    int   sel;
    int   i;
    for (int j = 0; j < n; j++) begin
      sel = $urandom_range(99);
      if (sel < 60 && tok_doc.size() != 0) begin
        i = $urandom_range(tok_doc.size() - 1);
        x = make_item(OP_RESAMPLE, tok_doc[i], tok_word[i], tok_topic[i]);
        send_item(x, r);
        if (!r.count_error) tok_topic[i] = r.topic_out;
      end else if (sel < 90) begin
        x = make_item(OP_ADD, $urandom_range(1) ? $urandom_range(7) : $urandom_range(1023),
                      $urandom_range(1) ? $urandom_range(15) : $urandom_range(4095),
                      $urandom_range(63));
        send_item(x, r);
        if (tok_doc.size() < 400) begin
          tok_doc.insert(tok_doc.size(), x.doc_index);
          tok_word.insert(tok_word.size(), x.word_id);
          tok_topic.insert(tok_topic.size(), r.topic_out);
        end
      end else begin
        x = make_item($urandom_range(1), $urandom_range(1023), $urandom_range(4095),
                      $urandom_range(63));
        send_item(x, r);
      end
    end
  endtask

  initial begin
    in_t  x;
    out_t r;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_ALPHA;
    cfg_data = '0;
    no_idle = 0;
    hold_req = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty tables, extremes, fraction extremes
    send_item(make_item(OP_RESAMPLE, 0, 0, 0), r);
    send_item(make_item(OP_ADD, 1023, 4095, 63), r);
    send_item(make_item(OP_ADD, 0, 0, 0), r);
    send_item(make_item(OP_ADD, 0, 0, 5), r);
    send_item(make_item(OP_ADD, 0, 1, 0), r);
    x = make_item(OP_RESAMPLE, 0, 0, 0);
    x.random_fraction = 32'd0;
    send_item(x, r);
    x = make_item(OP_RESAMPLE, 0, 0, r.topic_out);
    x.random_fraction = 32'hFFFF_FFFF;
    send_item(x, r);
    send_item(make_item(OP_RESAMPLE, 1023, 4095, 63), r);
    // old topic with a zero count in one table only
    send_item(make_item(OP_RESAMPLE, 0, 4095, 63), r);
    send_item(make_item(OP_RESAMPLE, 1023, 4095, 63), r);
    random_items(30);

    // low extremes: K and V below range clamp to one, zero priors
    set_all(0, 0, 0, 0);
    send_item(make_item(OP_ADD, 3, 3, 40), r);
    send_item(make_item(OP_RESAMPLE, 3, 3, 40), r);
    send_item(make_item(OP_RESAMPLE, 3, 3, 0), r);
    random_items(60);

    // high extremes: K and V above range clamp to the maximum
    set_all(24'hFF_FFFF, 24'hFF_FFFF, 127, 8191);
    random_items(20);

    set_all($urandom_range(24'hFF_FFFF), $urandom_range(24'hFF_FFFF), 4, 100);
    send_item(make_item(OP_ADD, 2, 2, 50), r);
    send_item(make_item(OP_RESAMPLE, 2, 2, 63), r);
    random_items(60);
    hold_req = 1'b1;
    random_items(60);
    // let the block drain completely before offering more
    while (sb.pending_q.size() != 0) @(negedge clk);
    random_items(80);

    set_all($urandom_range(200000), $urandom_range(20000), 8, 1);
    no_idle = 1;
    random_items(120);
    no_idle = 0;
    random_items(80);

    set_all(51200, 6554, 16, 4096);
    random_items(170);

    wait_drained();
    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("[lda_collapsed_gibbs_token_sampler_core] OK");
    end else begin
      $display("[lda_collapsed_gibbs_token_sampler_core] ERROR");
    end
    $finish;
  end
endmodule
